FILE: hdl/rrt_pkg.sv
// Package for the request tokenizer: byte codes, phase and kind enums,
// the classified byte record and the result record.
// No dependencies.
`timescale 1ns / 1ps

package rrt_pkg;

  // Default sizes handed to the top level
  localparam int LENGTH_WIDTH_DEF = 32;
  localparam int INDEX_WIDTH_DEF  = 21;
  localparam int IN_QUEUE_DEPTH   = 4;

  // Fixed field widths
  localparam int BYTE_W      = 8;
  localparam int OUT_INDEX_W = 21;
  localparam int MAX_ELEM_W  = 21;
  localparam int MAX_BULK_W  = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 1;

  // Result buffer in the back end
  localparam int OBUF_DEPTH = 4;
  localparam int OBUF_PTR_W = 2;
  localparam int OBUF_CNT_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ELEMENTS    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BULK_LENGTH = 1'd1;

  localparam logic [MAX_ELEM_W-1:0] MAX_ELEMENTS_RST    = 21'd1048576;
  localparam logic [MAX_BULK_W-1:0] MAX_BULK_LENGTH_RST = 32'hFFFF_FFFF;

  // Framing characters
  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_SP     = 8'h20;
  localparam logic [BYTE_W-1:0] CH_0      = 8'h30;
  localparam logic [BYTE_W-1:0] CH_9      = 8'h39;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_INLINE,
    PH_COUNT,
    PH_COUNT_LF,
    PH_DOLLAR,
    PH_LEN,
    PH_LEN_LF,
    PH_DATA,
    PH_TRAIL_CR,
    PH_TRAIL_LF
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_ELEM_END = 2'd1,
    KIND_REQ_END  = 2'd2,
    KIND_INVALID  = 2'd3
  } kind_t;

  // One request byte after classification
  typedef struct packed {
    logic [BYTE_W-1:0] byte_val;
    logic [3:0]        digit;
    logic              is_digit;
    logic              is_cr;
    logic              is_lf;
    logic              is_sp;
    logic              is_star;
    logic              is_dollar;
  } cls_t;

  // One result transaction
  typedef struct packed {
    kind_t                  kind;
    logic [BYTE_W-1:0]      data_byte;
    logic [OUT_INDEX_W-1:0] element_index;
    logic                   last_of_run;
  } res_t;

endpackage

FILE: hdl/rrt_queue.sv
// Small register FIFO between the classifier and the tokenizer.
// No package dependencies.
`timescale 1ns / 1ps

module rrt_queue #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output logic [WIDTH-1:0] head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full      = (cnt_r == FULL_CNT);
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // pointer and count update
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == LAST_PTR) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == LAST_PTR) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

FILE: hdl/rrt_front.sv
// Front end: accepts request bytes and classifies them for the tokenizer.
// Depends on rrt_pkg.
`timescale 1ns / 1ps

module rrt_front
  import rrt_pkg::*;
(
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              q_full,
  output logic              q_push,
  output cls_t              q_data
);

  logic [3:0] diff;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign diff     = in_byte[3:0] - CH_0[3:0];

  // character classes
  always_comb begin
    q_data           = '0;
    q_data.byte_val  = in_byte;
    q_data.digit     = diff;
    q_data.is_digit  = (in_byte inside {[CH_0:CH_9]});
    q_data.is_cr     = (in_byte == CH_CR);
    q_data.is_lf     = (in_byte == CH_LF);
    q_data.is_sp     = (in_byte == CH_SP);
    q_data.is_star   = (in_byte == CH_STAR);
    q_data.is_dollar = (in_byte == CH_DOLLAR);
  end

endmodule

FILE: hdl/rrt_back.sv
// Back end: tokenizer state machine, limit registers and result buffer.
// Depends on rrt_pkg.
`timescale 1ns / 1ps

module rrt_back
  import rrt_pkg::*;
#(
  parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF,
  parameter int INDEX_WIDTH  = INDEX_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  cls_t                   q_head,
  output logic                   q_pop,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output res_t                   out_res
);

  localparam int LW  = LENGTH_WIDTH;
  localparam int IW  = INDEX_WIDTH;
  localparam int NW  = (LW > IW) ? LW : IW;
  localparam int EW  = (IW > MAX_ELEM_W) ? IW : MAX_ELEM_W;
  localparam int BW  = (LW > MAX_BULK_W) ? LW : MAX_BULK_W;
  localparam int OW  = (IW > OUT_INDEX_W) ? IW : OUT_INDEX_W;
  localparam logic [IW-1:0] IDX_MAX = {IW{1'b1}};
  localparam logic [EW-1:0] IDX_MAX_E = EW'(IDX_MAX);
  localparam logic [OBUF_CNT_W-1:0] OBUF_ROOM = OBUF_CNT_W'(OBUF_DEPTH - 2);

  // state
  phase_t          phase_r, phase_nxt;
  logic [NW-1:0]   acc_r, acc_nxt;
  logic            digits_r, digits_nxt;
  logic [IW-1:0]   expected_r, expected_nxt;
  logic [IW-1:0]   counter_r, counter_nxt;
  logic [LW-1:0]   remain_r, remain_nxt;
  logic            pend_cr_r, pend_cr_nxt;
  logic            in_tok_r, in_tok_nxt;
  logic            halted_r, halted_nxt;
  logic [MAX_ELEM_W-1:0] max_elem_r;
  logic [MAX_BULK_W-1:0] max_bulk_r;

  // result buffer
  res_t                  obuf_r [OBUF_DEPTH];
  logic [OBUF_PTR_W-1:0] owr_r, ord_r;
  logic [OBUF_CNT_W-1:0] ocnt_r;

  logic            take, pop_out;
  res_t            res0, res1;
  logic [1:0]      n_res;
  logic [EW-1:0]   me_ext;
  logic [EW-1:0]   elim_e;
  logic [BW-1:0]   mb_ext;
  logic [LW-1:0]   llim;
  logic [NW-1:0]   limit;
  logic [NW+3:0]   prod;
  logic            over;
  logic [IW-1:0]   cnt_sat;
  logic [IW-1:0]   cnt_inc;

  function automatic logic [OUT_INDEX_W-1:0] to_out(input logic [IW-1:0] idx);
    logic [OW-1:0] w;
    w = OW'(idx);
    return w[OUT_INDEX_W-1:0];
  endfunction

  function automatic res_t mk(input kind_t k, input logic [BYTE_W-1:0] b,
                              input logic [IW-1:0] idx);
    res_t r;
    r.kind          = k;
    r.data_byte     = b;
    r.element_index = to_out(idx);
    r.last_of_run   = 1'b0;
    return r;
  endfunction

  assign take    = q_valid && (ocnt_r <= OBUF_ROOM);
  assign q_pop   = take;
  assign out_valid = (ocnt_r != '0);
  assign out_res   = obuf_r[ord_r];
  assign pop_out   = out_valid && !out_stall;

  // effective limits
  assign me_ext = EW'(max_elem_r);
  assign elim_e = (me_ext > IDX_MAX_E) ? IDX_MAX_E : me_ext;
  assign mb_ext = BW'(max_bulk_r);
  assign llim   = mb_ext[LW-1:0];
  assign limit  = (phase_r == PH_COUNT) ? NW'(elim_e) : NW'(llim);

  // decimal accumulate: acc * 10 + digit, checked against the limit
  assign prod = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + (NW+4)'(q_head.digit);
  assign over = (prod > (NW+4)'(limit));

  assign cnt_inc = counter_r + 1'b1;
  assign cnt_sat = (counter_r == IDX_MAX) ? counter_r : cnt_inc;

  // next state and results for one byte
  always_comb begin
    phase_nxt    = phase_r;
    acc_nxt      = acc_r;
    digits_nxt   = digits_r;
    expected_nxt = expected_r;
    counter_nxt  = counter_r;
    remain_nxt   = remain_r;
    pend_cr_nxt  = pend_cr_r;
    in_tok_nxt   = in_tok_r;
    halted_nxt   = halted_r;
    res0         = mk(KIND_INVALID, '0, '0);
    res1         = mk(KIND_INVALID, '0, '0);
    n_res        = 2'd0;

    if (take && !halted_r) begin
      case (phase_r)
        PH_IDLE, PH_INLINE: begin
          if (phase_r == PH_IDLE && q_head.is_star) begin
            acc_nxt    = '0;
            digits_nxt = 1'b0;
            phase_nxt  = PH_COUNT;
          end else if (q_head.is_lf) begin
            // line end: close open token, then request end; drop pending CR
            if (in_tok_r) begin
              res0  = mk(KIND_ELEM_END, '0, counter_r);
              res1  = mk(KIND_REQ_END, '0, cnt_sat);
              n_res = 2'd2;
            end else begin
              res0  = mk(KIND_REQ_END, '0, counter_r);
              n_res = 2'd1;
            end
            phase_nxt    = PH_IDLE;
            acc_nxt      = '0;
            digits_nxt   = 1'b0;
            expected_nxt = '0;
            counter_nxt  = '0;
            remain_nxt   = '0;
            pend_cr_nxt  = 1'b0;
            in_tok_nxt   = 1'b0;
          end else begin
            phase_nxt = PH_INLINE;
            // a held CR turns into content
            if (pend_cr_r) begin
              res0  = mk(KIND_DATA, CH_CR, counter_r);
              n_res = 2'd1;
            end
            if (q_head.is_cr) begin
              pend_cr_nxt = 1'b1;
              in_tok_nxt  = in_tok_r | pend_cr_r;
            end else if (q_head.is_sp) begin
              pend_cr_nxt = 1'b0;
              in_tok_nxt  = 1'b0;
              if (in_tok_r || pend_cr_r) begin
                counter_nxt = cnt_sat;
                if (pend_cr_r) begin
                  res1  = mk(KIND_ELEM_END, '0, counter_r);
                  n_res = 2'd2;
                end else begin
                  res0  = mk(KIND_ELEM_END, '0, counter_r);
                  n_res = 2'd1;
                end
              end
            end else begin
              pend_cr_nxt = 1'b0;
              in_tok_nxt  = 1'b1;
              if (pend_cr_r) begin
                res1  = mk(KIND_DATA, q_head.byte_val, counter_r);
                n_res = 2'd2;
              end else begin
                res0  = mk(KIND_DATA, q_head.byte_val, counter_r);
                n_res = 2'd1;
              end
            end
          end
        end
        PH_COUNT, PH_LEN: begin
          if (q_head.is_digit) begin
            if (over) begin
              halted_nxt = 1'b1;
              n_res      = 2'd1;
            end else begin
              acc_nxt    = prod[NW-1:0];
              digits_nxt = 1'b1;
            end
          end else if (q_head.is_cr && digits_r) begin
            if (phase_r == PH_COUNT) begin
              phase_nxt = PH_COUNT_LF;
              // zero element count is a protocol error
              if (acc_r == '0) begin
                halted_nxt = 1'b1;
                n_res      = 2'd1;
              end
            end else begin
              phase_nxt = PH_LEN_LF;
            end
          end else begin
            halted_nxt = 1'b1;
            n_res      = 2'd1;
          end
        end
        PH_COUNT_LF: begin
          if (q_head.is_lf) begin
            expected_nxt = acc_r[IW-1:0];
            counter_nxt  = '0;
            phase_nxt    = PH_DOLLAR;
          end else begin
            halted_nxt = 1'b1;
            n_res      = 2'd1;
          end
        end
        PH_DOLLAR: begin
          if (q_head.is_dollar) begin
            acc_nxt    = '0;
            digits_nxt = 1'b0;
            phase_nxt  = PH_LEN;
          end else begin
            halted_nxt = 1'b1;
            n_res      = 2'd1;
          end
        end
        PH_LEN_LF: begin
          if (q_head.is_lf) begin
            remain_nxt = acc_r[LW-1:0];
            phase_nxt  = (acc_r[LW-1:0] == '0) ? PH_TRAIL_CR : PH_DATA;
          end else begin
            halted_nxt = 1'b1;
            n_res      = 2'd1;
          end
        end
        PH_DATA: begin
          res0       = mk(KIND_DATA, q_head.byte_val, counter_r);
          n_res      = 2'd1;
          remain_nxt = remain_r - 1'b1;
          if (remain_r == LW'(1)) begin
            phase_nxt = PH_TRAIL_CR;
          end
        end
        PH_TRAIL_CR: begin
          if (q_head.is_cr) begin
            phase_nxt = PH_TRAIL_LF;
          end else begin
            halted_nxt = 1'b1;
            n_res      = 2'd1;
          end
        end
        PH_TRAIL_LF: begin
          if (q_head.is_lf) begin
            res0        = mk(KIND_ELEM_END, '0, counter_r);
            n_res       = 2'd1;
            counter_nxt = cnt_inc;
            if (cnt_inc >= expected_r) begin
              res1         = mk(KIND_REQ_END, '0, expected_r);
              n_res        = 2'd2;
              phase_nxt    = PH_IDLE;
              acc_nxt      = '0;
              digits_nxt   = 1'b0;
              expected_nxt = '0;
              counter_nxt  = '0;
              remain_nxt   = '0;
              pend_cr_nxt  = 1'b0;
              in_tok_nxt   = 1'b0;
            end else begin
              phase_nxt = PH_DOLLAR;
            end
          end else begin
            halted_nxt = 1'b1;
            n_res      = 2'd1;
          end
        end
        default: begin
          halted_nxt = 1'b1;
          n_res      = 2'd1;
        end
      endcase
    end

    // mark the final result of this byte
    if (n_res == 2'd1) begin
      res0.last_of_run = 1'b1;
    end else if (n_res == 2'd2) begin
      res1.last_of_run = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      acc_r      <= '0;
      digits_r   <= 1'b0;
      expected_r <= '0;
      counter_r  <= '0;
      remain_r   <= '0;
      pend_cr_r  <= 1'b0;
      in_tok_r   <= 1'b0;
      halted_r   <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      acc_r      <= acc_nxt;
      digits_r   <= digits_nxt;
      expected_r <= expected_nxt;
      counter_r  <= counter_nxt;
      remain_r   <= remain_nxt;
      pend_cr_r  <= pend_cr_nxt;
      in_tok_r   <= in_tok_nxt;
      halted_r   <= halted_nxt;
    end
  end

  // limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_elem_r <= MAX_ELEMENTS_RST;
      max_bulk_r <= MAX_BULK_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_ELEMENTS:    max_elem_r <= cfg_data[MAX_ELEM_W-1:0];
        REG_MAX_BULK_LENGTH: max_bulk_r <= cfg_data[MAX_BULK_W-1:0];
        default: ;
      endcase
    end
  end

  // result buffer pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r  <= '0;
      ord_r  <= '0;
      ocnt_r <= '0;
    end else begin
      owr_r  <= owr_r + OBUF_PTR_W'(n_res);
      ord_r  <= ord_r + OBUF_PTR_W'(pop_out);
      ocnt_r <= ocnt_r + OBUF_CNT_W'(n_res) - OBUF_CNT_W'(pop_out);
    end
  end

  // result buffer storage
  always_ff @(posedge clk) begin
    if (n_res != 2'd0) begin
      obuf_r[owr_r] <= res0;
    end
    if (n_res == 2'd2) begin
      obuf_r[owr_r + 1'b1] <= res1;
    end
  end

endmodule

FILE: hdl/resp_request_tokenizer.sv
// Top level of the request tokenizer: classifier, byte queue, tokenizer.
// Depends on rrt_pkg, rrt_front, rrt_queue and rrt_back.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  in_byte
//   out_     output     out_valid/out_stall  out_kind, out_data_byte,
//                                            out_element_index, out_last_of_run
//   cfg_     input      cfg_we               cfg_index, cfg_data
//
// One byte per cycle through the tokenizer when it causes at most one result
// and the result port is not stalled; a byte with two results writes both into
// the four-entry result buffer, which the single-result output drains in turn.
// An accepted byte is registered in the byte queue, then in the result buffer.
// Synchronous active-low reset; no clearing pass.
// in_stall rises only when the byte queue (four entries by default) is full.
`timescale 1ns / 1ps

module resp_request_tokenizer
  import rrt_pkg::*;
#(
  parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF,
  parameter int INDEX_WIDTH  = INDEX_WIDTH_DEF,
  parameter int QUEUE_DEPTH  = IN_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [BYTE_W-1:0]      in_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_kind,
  output logic [BYTE_W-1:0]      out_data_byte,
  output logic [OUT_INDEX_W-1:0] out_element_index,
  output logic                   out_last_of_run,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic q_full, q_push, q_pop, q_valid;
  cls_t q_in, q_head;
  logic [$bits(cls_t)-1:0] q_head_bits;
  res_t res;

  rrt_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  rrt_queue #(
    .WIDTH ($bits(cls_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head_bits)
  );

  assign q_head = cls_t'(q_head_bits);

  rrt_back #(
    .LENGTH_WIDTH (LENGTH_WIDTH),
    .INDEX_WIDTH  (INDEX_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_kind          = res.kind;
  assign out_data_byte     = res.data_byte;
  assign out_element_index = res.element_index;
  assign out_last_of_run   = res.last_of_run;

endmodule
